// File: src/rovc_pkg.sv
// Shared types and constants for the RGBA over compositor.
package rovc_pkg;

    localparam int PIX_W     = 8;
    localparam int IDX_W     = 24;
    localparam int WGT_W     = 16;
    localparam int NUM_W     = WGT_W + PIX_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int POS_W     = 12;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    // x / 255 == (x * RECIP_255) >> RECIP_SH for every x up to 255 * 255
    localparam int RECIP_255 = 32897;
    localparam int RECIP_SH  = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_X      = 3'd0,
        CFG_REGION_Y      = 3'd1,
        CFG_REGION_WIDTH  = 3'd2,
        CFG_REGION_HEIGHT = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic div_step;
        logic out_load;
    } rovc_cmd_t;

endpackage

// File: src/rovc_div_lane.sv
// Restoring radix-2 divider lane, one quotient bit per step.
module rovc_div_lane (
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             step,
    input  logic [rovc_pkg::NUM_W-1:0]       num,
    input  logic [rovc_pkg::WGT_W-1:0]       den,
    output logic [rovc_pkg::PIX_W-1:0]       quo
);

    localparam int SH_W = rovc_pkg::NUM_W - 1;

    logic [rovc_pkg::NUM_W-1:0] rem_reg;
    logic [SH_W-1:0]            dsh_reg;
    logic [rovc_pkg::PIX_W-1:0] quo_reg;
    logic                       fits;

    assign fits = rem_reg >= {1'b0, dsh_reg};

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= num;
            dsh_reg <= {den, (rovc_pkg::PIX_W-1)'(0)};
            quo_reg <= '0;
        end else if (step) begin
            if (fits) begin
                rem_reg <= rem_reg - {1'b0, dsh_reg};
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[rovc_pkg::PIX_W-2:0], fits};
        end
    end

    assign quo = quo_reg;

endmodule

// File: src/rovc_dp.sv
// Datapath: config registers, raster counters, blend weights, dividers, result register.
module rovc_dp #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rovc_pkg::rovc_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [rovc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rovc_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic [8*rovc_pkg::PIX_W-1:0]        in_pix,
    output logic [rovc_pkg::PIX_W-1:0]          out_alpha,
    output logic [rovc_pkg::PIX_W-1:0]          out_red,
    output logic [rovc_pkg::PIX_W-1:0]          out_green,
    output logic [rovc_pkg::PIX_W-1:0]          out_blue,
    output logic [rovc_pkg::IDX_W-1:0]          pixel_index,
    output logic                                changed,
    output logic                                last_pixel
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PW    = rovc_pkg::PIX_W;
    localparam int IW    = rovc_pkg::IDX_W;
    localparam int WW    = rovc_pkg::WGT_W;
    localparam int NW    = rovc_pkg::NUM_W;
    localparam int DW    = rovc_pkg::CFG_DAT_W;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_COPY,
        MODE_BLEND
    } mode_t;

    // configuration
    logic [rovc_pkg::POS_W-1:0] region_x_reg, region_y_reg;
    logic [DW-1:0]              region_w_reg, region_h_reg, frame_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_x_reg <= '0;
            region_y_reg <= '0;
            region_w_reg <= DW'(1);
            region_h_reg <= DW'(1);
            frame_w_reg  <= DW'(1);
        end else if (cfg_we) begin
            case (rovc_pkg::cfg_idx_t'(cfg_index))
                rovc_pkg::CFG_REGION_X:      region_x_reg <= cfg_data[rovc_pkg::POS_W-1:0];
                rovc_pkg::CFG_REGION_Y:      region_y_reg <= cfg_data[rovc_pkg::POS_W-1:0];
                rovc_pkg::CFG_REGION_WIDTH:  region_w_reg <= cfg_data;
                rovc_pkg::CFG_REGION_HEIGHT: region_h_reg <= cfg_data;
                rovc_pkg::CFG_FRAME_WIDTH:   frame_w_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // last column / row positions after clamping
    logic [CNT_W-1:0] col_lim, row_lim;

    always_comb begin
        if (region_w_reg == '0) begin
            col_lim = '0;
        end else if (32'(region_w_reg) > 32'(MAX_DIM)) begin
            col_lim = CNT_W'(MAX_DIM - 1);
        end else begin
            col_lim = CNT_W'(region_w_reg - DW'(1));
        end
        if (region_h_reg == '0) begin
            row_lim = '0;
        end else if (32'(region_h_reg) > 32'(MAX_DIM)) begin
            row_lim = CNT_W'(MAX_DIM - 1);
        end else begin
            row_lim = CNT_W'(region_h_reg - DW'(1));
        end
    end

    // raster counters
    logic [CNT_W-1:0] col_reg, row_reg, col_next, row_next;
    logic             end_col, end_row;

    assign end_col = col_reg >= col_lim;
    assign end_row = row_reg >= row_lim;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept) begin
            if (end_col) begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // captured transaction
    logic [PW-1:0]    sa_reg, sr_reg, sg_reg, sb_reg, da_reg, dr_reg, dg_reg, db_reg;
    logic [CNT_W-1:0] col_cap_reg, row_cap_reg;
    logic             last_cap_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sa_reg       <= in_pix[0*PW +: PW];
            sr_reg       <= in_pix[1*PW +: PW];
            sg_reg       <= in_pix[2*PW +: PW];
            sb_reg       <= in_pix[3*PW +: PW];
            da_reg       <= in_pix[4*PW +: PW];
            dr_reg       <= in_pix[5*PW +: PW];
            dg_reg       <= in_pix[6*PW +: PW];
            db_reg       <= in_pix[7*PW +: PW];
            col_cap_reg  <= col_reg;
            row_cap_reg  <= row_reg;
            last_cap_reg <= end_col && end_row;
        end
    end

    // weights and row offset
    logic [WW-1:0] u_reg, v_reg;
    logic [IW-1:0] yprod_reg, idx_reg;
    mode_t         mode_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            u_reg     <= {sa_reg, PW'(0)} - WW'(sa_reg);
            v_reg     <= WW'(PW'(8'd255) - sa_reg) * WW'(da_reg);
            yprod_reg <= (IW'(region_y_reg) + IW'(row_cap_reg)) * IW'(frame_w_reg);
            if (sa_reg == '0) begin
                mode_reg <= MODE_KEEP;
            end else if (sa_reg == '1 || da_reg == '0) begin
                mode_reg <= MODE_COPY;
            end else begin
                mode_reg <= MODE_BLEND;
            end
        end
        if (cmd.mul2) begin
            idx_reg <= yprod_reg + IW'(region_x_reg) + IW'(col_cap_reg);
        end
    end

    // dividers
    logic [WW-1:0] tot;
    logic [NW-1:0] num_r, num_g, num_b;
    logic [PW-1:0] q_r, q_g, q_b;

    assign tot   = u_reg + v_reg;
    assign num_r = NW'(sr_reg) * NW'(u_reg) + NW'(dr_reg) * NW'(v_reg);
    assign num_g = NW'(sg_reg) * NW'(u_reg) + NW'(dg_reg) * NW'(v_reg);
    assign num_b = NW'(sb_reg) * NW'(u_reg) + NW'(db_reg) * NW'(v_reg);

    // alpha: tot / 255 by reciprocal multiply
    logic [31:0]   a_prod;
    logic [PW-1:0] q_a_reg;

    assign a_prod = 32'(tot) * 32'(rovc_pkg::RECIP_255);

    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            q_a_reg <= a_prod[rovc_pkg::RECIP_SH +: PW];
        end
    end

    rovc_div_lane u_div_r (
        .aclk (aclk), .load (cmd.mul2), .step (cmd.div_step),
        .num  (num_r), .den (tot), .quo (q_r)
    );
    rovc_div_lane u_div_g (
        .aclk (aclk), .load (cmd.mul2), .step (cmd.div_step),
        .num  (num_g), .den (tot), .quo (q_g)
    );
    rovc_div_lane u_div_b (
        .aclk (aclk), .load (cmd.mul2), .step (cmd.div_step),
        .num  (num_b), .den (tot), .quo (q_b)
    );

    // result register
    logic [PW-1:0] oa_reg, or_reg, og_reg, ob_reg;
    logic [IW-1:0] oidx_reg;
    logic          chg_reg, olast_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            oidx_reg  <= idx_reg;
            olast_reg <= last_cap_reg;
            case (mode_reg)
                MODE_KEEP: begin
                    oa_reg  <= da_reg;
                    or_reg  <= dr_reg;
                    og_reg  <= dg_reg;
                    ob_reg  <= db_reg;
                    chg_reg <= 1'b0;
                end
                MODE_COPY: begin
                    oa_reg  <= sa_reg;
                    or_reg  <= sr_reg;
                    og_reg  <= sg_reg;
                    ob_reg  <= sb_reg;
                    chg_reg <= 1'b1;
                end
                default: begin
                    oa_reg  <= q_a_reg;
                    or_reg  <= q_r;
                    og_reg  <= q_g;
                    ob_reg  <= q_b;
                    chg_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_alpha   = oa_reg;
    assign out_red     = or_reg;
    assign out_green   = og_reg;
    assign out_blue    = ob_reg;
    assign pixel_index = oidx_reg;
    assign changed     = chg_reg;
    assign last_pixel  = olast_reg;

endmodule

// File: src/rovc_ctrl.sv
// Controller: sequences one pixel through multiply, divide and result load.
module rovc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rovc_pkg::rovc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                       state_reg, state_next;
    logic [rovc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        step_next    = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + rovc_pkg::STEP_W'(1);
                if (step_reg == rovc_pkg::STEP_W'(rovc_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: src/rgba_over_compositor_core.sv
// Top level of the non-premultiplied RGBA over compositor.
//
//  port group  direction  transaction
//  s_*         in         one source and destination pixel pair
//  m_*         out        one blended pixel with frame index
//  cfg_*       in         one register write, always ready
//
// A pixel passes through accept, multiply, eight restoring divide steps in three
// color lanes side by side, and a result load.
// The next pixel is accepted while the previous result waits in the output register.
// aresetn is synchronous, active low; resets config, raster counters and controller.
// A stalled result holds the pipeline in its final state, ST_FIN, until taken.
module rgba_over_compositor_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // src_alpha, src_red, src_green, src_blue, dst_alpha, dst_red, dst_green, dst_blue
    input  logic [63:0]                           s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_alpha, out_red, out_green, out_blue, pixel_index
    output logic [55:0]                           m_tdata,
    // changed
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rovc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rovc_pkg::CFG_DAT_W-1:0]        cfg_data
);

    rovc_pkg::rovc_cmd_t            cmd;
    logic [rovc_pkg::PIX_W-1:0]     out_alpha, out_red, out_green, out_blue;
    logic [rovc_pkg::IDX_W-1:0]     pixel_index;

    assign cfg_ready = 1'b1;

    rovc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rovc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_pix      (s_tdata),
        .out_alpha   (out_alpha),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .pixel_index (pixel_index),
        .changed     (m_tuser),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {pixel_index, out_blue, out_green, out_red, out_alpha};

endmodule
